[hdl/stobs_pkg.sv]
package stobs_pkg;

  localparam int DW = 32;
  localparam int GW = 31;
  localparam int FW = 16;
  localparam int RW = 24;

  // register indexes
  localparam logic [1:0] REG_DECAY = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

  localparam logic [FW-1:0] DECAY_RST = 16'd64880;
  localparam logic [GW-1:0] GAIN_RST  = 31'd65536;
  localparam logic [DW-1:0] STEP_RST  = 32'd214748;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_P1,
    OP_P2,
    OP_PRED,
    OP_ERR,
    OP_SQRT,
    OP_PROP,
    OP_STEP,
    OP_EMF,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       ax;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } stat_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[DW-1:0];
  endfunction

endpackage

[hdl/stobs_if.sv]
interface stobs_in_if (input logic clk);
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     volt_alpha;
  logic signed [31:0]     volt_beta;
  logic signed [31:0]     curr_alpha;
  logic signed [31:0]     curr_beta;
  logic [30:0]            root_gain;
  logic [30:0]            integral_gain;
  logic [30:0]            integral_limit;
  modport source (output valid, volt_alpha, volt_beta, curr_alpha, curr_beta,
                  root_gain, integral_gain, integral_limit, input ready);
  modport sink (input valid, volt_alpha, volt_beta, curr_alpha, curr_beta,
                root_gain, integral_gain, integral_limit, output ready);
endinterface

interface stobs_out_if (input logic clk);
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     emf_alpha;
  logic signed [31:0]     emf_beta;
  logic signed [31:0]     error_alpha;
  logic signed [31:0]     error_beta;
  logic signed [31:0]     pred_alpha;
  logic signed [31:0]     pred_beta;
  modport source (output valid, emf_alpha, emf_beta, error_alpha, error_beta,
                  pred_alpha, pred_beta, input ready);
  modport sink (input valid, emf_alpha, emf_beta, error_alpha, error_beta,
                pred_alpha, pred_beta, output ready);
endinterface

[hdl/stobs_ctrl.sv]
module stobs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_fire,
  input  stobs_pkg::stat_t stat,
  output stobs_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_valid
);
  import stobs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_PRED, S_ERR, S_SQRT, S_PROP, S_STEP, S_EMF, S_OUT
  } state_t;

  state_t state;
  logic   ax;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd.ax = ax;
    unique case (state)
      S_IDLE: cmd.op = in_fire ? OP_LOAD : OP_NONE;
      S_P1:   cmd.op = OP_P1;
      S_P2:   cmd.op = OP_P2;
      S_PRED: cmd.op = OP_PRED;
      S_ERR:  cmd.op = OP_ERR;
      S_SQRT: cmd.op = OP_SQRT;
      S_PROP: cmd.op = OP_PROP;
      S_STEP: cmd.op = OP_STEP;
      S_EMF:  cmd.op = OP_EMF;
      S_OUT:  cmd.op = OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // sequencer: one axis after the other
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ax        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          state <= S_P1;
          ax    <= 1'b0;
        end
        S_P1:   state <= S_P2;
        S_P2:   state <= S_PRED;
        S_PRED: state <= S_ERR;
        S_ERR:  state <= S_SQRT;
        S_SQRT: if (stat.sqrt_done) state <= S_PROP;
        S_PROP: state <= S_STEP;
        S_STEP: state <= S_EMF;
        S_EMF: begin
          if (ax) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            state <= S_P1;
            ax    <= 1'b1;
          end
        end
        S_OUT: if (out_fire) begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready) else $error("accept while busy");
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept with pending result");
endmodule

[hdl/stobs_dp.sv]
module stobs_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  stobs_pkg::cmd_t         cmd,
  output stobs_pkg::stat_t        stat,
  input  logic [15:0]             decay,
  input  logic [30:0]             gain,
  input  logic [31:0]             step_time,
  input  logic signed [31:0]      in_v [2],
  input  logic signed [31:0]      in_i [2],
  input  logic [30:0]             in_k1,
  input  logic [30:0]             in_k2,
  input  logic [30:0]             in_lim,
  output logic signed [31:0]      res_z [2],
  output logic signed [31:0]      res_e [2],
  output logic signed [31:0]      res_p [2]
);
  import stobs_pkg::*;

  // item registers
  logic signed [31:0] v [2];
  logic signed [31:0] ci [2];
  logic [30:0] k1, k2, lim;
  // observer state
  logic signed [31:0] pc [2];
  logic signed [31:0] wi [2];
  logic signed [31:0] lz [2];
  // scratch
  logic signed [49:0] t1;
  logic signed [64:0] t2;
  logic signed [31:0] pred, err;
  logic [47:0] rad;
  logic [23:0] root;
  logic [48:0] rem;
  logic [4:0]  cnt;
  logic [47:0] prop;
  logic [31:0] stp;
  logic        busy;

  logic signed [32:0] dv;
  logic signed [33:0] r1;
  logic signed [49:0] r2;
  logic signed [33:0] de;
  logic signed [31:0] es;
  logic [31:0] mag;
  logic [48:0] trial;
  logic signed [33:0] wn;
  logic signed [33:0] lim_s;

  assign dv = 33'(v[cmd.ax]) - 33'(lz[cmd.ax]);
  assign r1 = 34'(t1 + 50'sd32768 >>> FW);
  assign r2 = 50'(t2 + 65'sd32768 >>> FW);
  assign de = 34'(pred) - 34'(ci[cmd.ax]);
  // saturated error and its magnitude
  assign es = sat32(66'(de));
  assign mag = (es < 0) ? 32'(-34'(es)) : 32'(es);
  assign trial = {rem[46:0], rad[47:46]} - {23'd0, root, 2'b01};
  assign stat.sqrt_done = busy && (cnt == 5'd23);
  assign lim_s = $signed({3'b000, lim});

  always_comb begin
    wn = 34'(wi[cmd.ax]);
    if (err > 0) wn = wn + 34'(stp);
    else if (err < 0) wn = wn - 34'(stp);
    if (wn > lim_s) wn = lim_s;
    if (wn < -lim_s) wn = -lim_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc[0] <= '0; pc[1] <= '0; wi[0] <= '0; wi[1] <= '0;
      lz[0] <= '0; lz[1] <= '0;
      busy  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          v <= in_v; ci <= in_i; k1 <= in_k1; k2 <= in_k2; lim <= in_lim;
        end
        // one multiply per step
        OP_P1: t1 <= $signed({1'b0, decay}) * pc[cmd.ax];
        OP_P2: t2 <= $signed({1'b0, gain}) * dv;
        OP_PRED: pred <= sat32(66'(r1) + 66'(r2));
        OP_ERR: begin
          err  <= es;
          res_p[cmd.ax] <= pred;
          pc[cmd.ax] <= pred;
          rad  <= {mag, 16'd0};
          root <= '0; rem <= '0; cnt <= '0; busy <= 1'b1;
        end
        // restoring square root, one result bit per cycle
        OP_SQRT: if (busy) begin
          if (!trial[48]) begin
            rem  <= trial; root <= {root[22:0], 1'b1};
          end else begin
            rem  <= {rem[46:0], rad[47:46]}; root <= {root[22:0], 1'b0};
          end
          rad <= {rad[45:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd23) busy <= 1'b0;
        end
        OP_PROP: prop <= 48'((55'(k1) * 55'(root) + 55'd32768) >> FW);
        OP_STEP: stp <= 32'((64'(step_time) * 64'(k2) + 64'h80000000) >> 32);
        OP_EMF: begin
          res_e[cmd.ax] <= err;
          wi[cmd.ax]    <= wn[31:0];
          if (err > 0) begin
            res_z[cmd.ax] <= sat32(66'(prop) + 66'(wi[cmd.ax]));
            lz[cmd.ax]    <= sat32(66'(prop) + 66'(wi[cmd.ax]));
          end else if (err < 0) begin
            res_z[cmd.ax] <= sat32(66'(wi[cmd.ax]) - 66'(prop));
            lz[cmd.ax]    <= sat32(66'(wi[cmd.ax]) - 66'(prop));
          end else begin
            res_z[cmd.ax] <= wi[cmd.ax];
            lz[cmd.ax]    <= wi[cmd.ax];
          end
        end
        default: ;
      endcase
    end
  end

  a_lim: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMF |=> (wi[$past(cmd.ax)] <= $signed({1'b0, lim})))
    else $error("integral beyond clamp");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == 5'd0 || cnt == 5'd24) else $error("root counter");
  a_done: assert property (@(posedge clk) disable iff (rst)
    stat.sqrt_done |=> !busy) else $error("root not finished");
endmodule

[hdl/super_twisting_emf_observer_top.sv]
// Super-twisting EMF observer, two axes per item.
// Input channel in: voltages, currents and k1, k2, clamp for one tick.
// Output channel out: emf, error and predicted current for both axes.
// APB port sets predictor_decay (0x0), predictor_gain (0x4), step_time
// (0x8); pready is always high, reads return the register.
// Each axis runs through a shared sequence: two multiplies, predictor sum,
// error, a restoring square root, gain multiply, step multiply and
// integral update. One item is in work at a time; the next word is taken
// the cycle after the result is taken. While out.valid is high and the
// receiver stalls, the result holds and no new word is accepted.
// Reset (rst, synchronous) clears observer state and restores registers.
module super_twisting_emf_observer_top (
  input  logic        clk,
  input  logic        rst,
  stobs_in_if.sink    in,
  stobs_out_if.source out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stobs_pkg::*;

  logic [FW-1:0] decay;
  logic [GW-1:0] gain;
  logic [DW-1:0] step_time;
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, out_fire;
  logic signed [31:0] vv [2], ii [2], zz [2], ee [2], pp [2];

  assign pready   = 1'b1;
  assign in_fire  = in.valid && in.ready;
  assign out_fire = out.valid && out.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= DECAY_RST; gain <= GAIN_RST; step_time <= STEP_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[3:2] == REG_DECAY) decay <= pwdata[15:0];
      if (paddr[3:2] == REG_GAIN) gain <= pwdata[30:0];
      if (paddr[3:2] == REG_STEP) step_time <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DECAY: prdata = {16'd0, decay};
      REG_GAIN:  prdata = {1'b0, gain};
      REG_STEP:  prdata = step_time;
      default:   prdata = '0;
    endcase
  end

  assign vv[0] = in.volt_alpha;
  assign vv[1] = in.volt_beta;
  assign ii[0] = in.curr_alpha;
  assign ii[1] = in.curr_beta;

  stobs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .stat, .cmd,
    .in_ready(in.ready), .out_valid(out.valid)
  );

  stobs_dp u_dp (
    .clk, .rst, .cmd, .stat, .decay, .gain, .step_time,
    .in_v(vv), .in_i(ii), .in_k1(in.root_gain), .in_k2(in.integral_gain),
    .in_lim(in.integral_limit), .res_z(zz), .res_e(ee), .res_p(pp)
  );

  assign out.emf_alpha   = zz[0];
  assign out.emf_beta    = zz[1];
  assign out.error_alpha = ee[0];
  assign out.error_beta  = ee[1];
  assign out.pred_alpha  = pp[0];
  assign out.pred_beta   = pp[1];
endmodule

[tb/stobs_observer_checker.sv]
`timescale 1ns / 1ps

module stobs_observer_checker (
  input  logic        clk,
  input  logic        rst,
  stobs_in_if         in_mon,
  stobs_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          words_in,
  output int          words_out,
  output int          pending
);
  import stobs_pkg::*;

  typedef struct packed {
    logic signed [31:0] emf_a;
    logic signed [31:0] emf_b;
    logic signed [31:0] err_a;
    logic signed [31:0] err_b;
    logic signed [31:0] pred_a;
    logic signed [31:0] pred_b;
  } emf_result_t;

  emf_result_t expected_emf_q[$];

  // observer copy of registers and per-axis state
  logic [FW-1:0]      decay;
  logic [GW-1:0]      gain;
  logic [DW-1:0]      period;
  logic signed [31:0] pred_st[2];
  logic signed [31:0] integ_st[2];
  logic signed [31:0] emf_st[2];

  initial begin
    fail_count = 0;
    words_in   = 0;
    words_out  = 0;
    pending    = 0;
  end

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) return 32'sh7fffffff;
    if (x < -80'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // one axis of the super-twisting update
  task automatic axis_update(input int ax, input logic signed [31:0] v,
                             input logic signed [31:0] i, input logic [30:0] k1,
                             input logic [30:0] k2, input logic [30:0] lim,
                             output logic signed [31:0] z, output logic signed [31:0] e,
                             output logic signed [31:0] p);
    logic signed [79:0] dec80, gain80, pv80, v80, z80, i80, t1, t2, r1, r2;
    logic signed [79:0] w, lim80, prop80, stp80, e80;
    logic [63:0] mag, root, prop, stp;
    dec80  = {64'd0, decay};
    gain80 = {49'd0, gain};
    pv80   = pred_st[ax];
    v80    = v;
    z80    = emf_st[ax];
    i80    = i;
    t1 = dec80 * pv80;
    t2 = gain80 * (v80 - z80);
    r1 = (t1 + 80'sd32768) >>> 16;
    r2 = (t2 + 80'sd32768) >>> 16;
    p  = clip32(r1 + r2);
    e  = clip32(80'(p) - i80);
    e80 = e;
    mag = (e80 < 0) ? 64'(-e80) : 64'(e80);
    root = int_root(mag << 16);
    prop = (64'(k1) * root + 64'd32768) >> 16;
    stp  = (64'(period) * 64'(k2) + 64'h80000000) >> 32;
    prop80 = {16'd0, prop};
    stp80  = {16'd0, stp};
    lim80  = {49'd0, lim};
    w = integ_st[ax];
    if (e80 > 0) begin
      z = clip32(w + prop80);
      w = w + stp80;
    end else if (e80 < 0) begin
      z = clip32(w - prop80);
      w = w - stp80;
    end else begin
      z = clip32(w);
    end
    if (w > lim80) w = lim80;
    if (w < -lim80) w = -lim80;
    pred_st[ax]  = p;
    integ_st[ax] = w[31:0];
    emf_st[ax]   = z;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // register writes, prediction on accepted words, comparison on results
  always @(posedge clk) begin
    emf_result_t r;
    if (rst) begin
      decay  = DECAY_RST;
      gain   = GAIN_RST;
      period = STEP_RST;
      for (int k = 0; k < 2; k++) begin
        pred_st[k]  = 0;
        integ_st[k] = 0;
        emf_st[k]   = 0;
      end
      expected_emf_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DECAY: decay  = pwdata[FW-1:0];
          REG_GAIN:  gain   = pwdata[GW-1:0];
          REG_STEP:  period = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        axis_update(0, in_mon.volt_alpha, in_mon.curr_alpha, in_mon.root_gain,
                    in_mon.integral_gain, in_mon.integral_limit, r.emf_a, r.err_a, r.pred_a);
        axis_update(1, in_mon.volt_beta, in_mon.curr_beta, in_mon.root_gain,
                    in_mon.integral_gain, in_mon.integral_limit, r.emf_b, r.err_b, r.pred_b);
        expected_emf_q.push_back(r);
        words_in++;
      end
      if (out_mon.valid && out_mon.ready) begin
        words_out++;
        if (expected_emf_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          r = expected_emf_q.pop_front();
          check_field("emf_alpha", r.emf_a, out_mon.emf_alpha);
          check_field("emf_beta", r.emf_b, out_mon.emf_beta);
          check_field("error_alpha", r.err_a, out_mon.error_alpha);
          check_field("error_beta", r.err_b, out_mon.error_beta);
          check_field("pred_alpha", r.pred_a, out_mon.pred_alpha);
          check_field("pred_beta", r.pred_b, out_mon.pred_beta);
        end
      end
      pending = expected_emf_q.size();
    end
  end

endmodule

[tb/super_twisting_emf_observer_top_test.sv]
`timescale 1ns / 1ps

module super_twisting_emf_observer_top_test;
  import stobs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          words_in;
  int          words_out;
  int          pending;
  int          cycles;
  int          burst_left;
  int          cfg_writes;

  stobs_in_if  in_ch (clk);
  stobs_out_if out_ch (clk);

  super_twisting_emf_observer_top DUT (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stobs_observer_checker u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .words_in(words_in), .words_out(words_out), .pending(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("super_twisting_emf_observer_top test failed");
      $finish;
    end
  end

  // receiver stall pattern: always ready, random, or mostly stalled
  int stall_mode;
  int stall_left;
  initial begin
    stall_mode = 0;
    stall_left = 100;
  end
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_writes++;
  endtask

  // stop sending, wait until every expected word has come back, then settle
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [31:0] va, input logic [31:0] vb,
                           input logic [31:0] ca, input logic [31:0] cb,
                           input logic [30:0] k1, input logic [30:0] k2,
                           input logic [30:0] lim);
    int seen;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    seen = words_in;
    in_ch.volt_alpha     = va;
    in_ch.volt_beta      = vb;
    in_ch.curr_alpha     = ca;
    in_ch.curr_beta      = cb;
    in_ch.root_gain      = k1;
    in_ch.integral_gain  = k2;
    in_ch.integral_limit = lim;
    in_ch.valid          = 1'b1;
    do @(negedge clk); while (words_in == seen);
  endtask

  function automatic logic [31:0] rand_signal(input bit full);
    logic [31:0] x;
    x = $urandom;
    if (!full) x = $signed(x) >>> $urandom_range(8, 20);
    return x;
  endfunction

  function automatic logic [30:0] rand_gain(input bit full);
    logic [30:0] x;
    x = $urandom;
    if (!full) x = x >> $urandom_range(8, 24);
    return x;
  endfunction

  task automatic send_random();
    bit full;
    full = ($urandom_range(0, 9) < 3);
    send_word(rand_signal(full), rand_signal(full), rand_signal(full), rand_signal(full),
              rand_gain(full), rand_gain(full), rand_gain(full));
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    cfg_writes = 0;
    in_ch.valid = 1'b0;
    in_ch.volt_alpha = '0;
    in_ch.volt_beta = '0;
    in_ch.curr_alpha = '0;
    in_ch.curr_beta = '0;
    in_ch.root_gain = '0;
    in_ch.integral_gain = '0;
    in_ch.integral_limit = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // zero error from reset state
    send_word(0, 0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    // field extremes, saturation both ways
    send_word(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_word(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_word(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              0, 0, 0);
    // build up the integral, then shrink the clamp, then zero it
    repeat (4) send_word(32'h00050000, 32'hfffb0000, 32'hfff00000, 32'h00100000,
                         31'h00020000, 31'h7fffffff, 31'h7fffffff);
    send_word(32'h00050000, 32'hfffb0000, 32'hfff00000, 32'h00100000,
              31'h00020000, 31'h7fffffff, 31'h00001000);
    send_word(32'h00010000, 32'hffff0000, 32'h00000000, 32'h00000000,
              31'h00020000, 31'h00010000, 0);
    send_word(0, 0, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000);
    drain_results();

    // register extremes, then an out-of-range index
    apb_write(4'h0, 32'h0000ffff);
    apb_write(4'h4, 32'h7fffffff);
    apb_write(4'h8, 32'hffffffff);
    apb_write(4'hc, 32'hffffffff);
    send_word(32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff,
              31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_word(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              31'h7fffffff, 31'h7fffffff, 31'h40000000);
    send_word(32'h00000001, 32'h00000000, 32'h00000000, 32'h00000001,
              31'h00000001, 31'h00000001, 31'h00000001);
    drain_results();
    apb_write(4'h0, 32'h0);
    apb_write(4'h4, 32'h0);
    apb_write(4'h8, 32'h0);
    send_word(32'h00030000, 32'hfffd0000, 32'h00010000, 32'hffff0000,
              31'h00010000, 31'h00010000, 31'h00010000);
    send_word(32'h00030000, 32'hfffd0000, 32'h00010000, 32'hffff0000,
              31'h00010000, 31'h00010000, 31'h00010000);
    drain_results();

    // random phases with a new register setting each time
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          apb_write(4'h0, 32'd64880);
          apb_write(4'h4, 32'd65536);
          apb_write(4'h8, 32'd214748);
        end
        1: begin
          apb_write(4'h0, 32'h0000ffff);
          apb_write(4'h4, 32'h7fffffff);
          apb_write(4'h8, 32'hffffffff);
        end
        2: begin
          apb_write(4'h0, 32'h0);
          apb_write(4'h4, 32'h0);
          apb_write(4'h8, 32'h0);
        end
        default: begin
          apb_write(4'h0, $urandom);
          apb_write(4'h4, $urandom >> $urandom_range(0, 14));
          apb_write(4'h8, $urandom >> $urandom_range(0, 16));
        end
      endcase
      repeat (220) send_random();
      drain_results();
    end

    repeat (40) @(negedge clk);
    $display("%0d words sent, %0d results checked, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("covered field extremes, zero error, clamp shrink, saturation, six settings");
    if (fail_count == 0 && pending == 0) begin
      $display("super_twisting_emf_observer_top test passed");
    end else begin
      $display("super_twisting_emf_observer_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/stobs_pkg.sv
hdl/stobs_if.sv
hdl/stobs_ctrl.sv
hdl/stobs_dp.sv
hdl/super_twisting_emf_observer_top.sv
tb/stobs_observer_checker.sv
tb/super_twisting_emf_observer_top_test.sv
